>>> sv/bffa_pkg.sv
package bffa_pkg;

  localparam int unsigned MAP_CAPACITY_DEF = 4096;

  localparam int unsigned CFG_W   = 13;
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned LEN_W   = 13;
  localparam int unsigned WORD_W  = 8;
  localparam int unsigned BIT_W   = $clog2(WORD_W);

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4096);

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_SET    = 2'd1,
    REQ_STATUS = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_BIT,
    ST_RESP
  } state_e;

endpackage

>>> sv/bffa_ram.sv
module bffa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/bitmap_first_fit_allocator_unit.sv
// Bitmap allocator over MAP_CAPACITY occupancy bits, held in one RAM of 8-bit words
// (ceil(MAP_CAPACITY/8) words, one read and one write port, registered read). Every
// request gives one result. A set or status request reads its word, and a set writes
// it back; one outside the map in use fails at once. An allocate request streams
// the words of the map in use through a 13-bit run counter, one word a cycle, until
// the first fitting run ends, then reads, merges and writes back the words that the
// run covers; one that finds no run scans the whole map in use, and one with a length
// of zero or above the map in use fails without a scan. A clear request and the
// clearing pass after reset each write every RAM word once, and no request is taken
// while they run; configuration writes are taken at any time.
module bitmap_first_fit_allocator_unit #(
  parameter int unsigned MAP_CAPACITY = bffa_pkg::MAP_CAPACITY_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bffa_pkg::CFG_W-1:0]  cfg_map_bits_in_use_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [bffa_pkg::REQ_W-1:0]  req_type_i,
  input  logic [bffa_pkg::IDX_W-1:0]  bit_pos_i,
  input  logic [bffa_pkg::LEN_W-1:0]  run_length_i,
  input  logic                        set_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        failed_o,
  output logic [bffa_pkg::IDX_W-1:0]  run_start_o,
  output logic                        bit_busy_o
);

  import bffa_pkg::*;

  localparam int unsigned DEPTH = (MAP_CAPACITY + WORD_W - 1) / WORD_W;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PW    = AW + BIT_W;

  state_e             state_q, state_d;
  logic [CFG_W-1:0]   cfg_q;
  req_type_e          req_q, req_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic               val_q, val_d;
  logic [AW-1:0]      issue_q, issue_d;
  logic [AW-1:0]      proc_q, proc_d;
  logic [AW-1:0]      last_q, last_d;
  logic               rd_vld_q, rd_vld_d;
  logic [LEN_W-1:0]   run_q, run_d;
  logic [PW-1:0]      start_q, start_d;
  logic [PW-1:0]      end_q, end_d;
  logic               clr_resp_q, clr_resp_d;
  logic               res_failed_q, res_failed_d;
  logic [IDX_W-1:0]   res_start_q, res_start_d;
  logic               res_occ_q, res_occ_d;
  logic               out_valid_q, out_valid_d;
  logic               out_failed_q, out_failed_d;
  logic [IDX_W-1:0]   out_start_q, out_start_d;
  logic               out_occ_q, out_occ_d;

  logic [CFG_W-1:0]   map_size;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [WORD_W-1:0]  ram_rdata;

  logic [LEN_W-1:0]   scan_run;
  logic               scan_found;
  logic [PW-1:0]      scan_end;
  logic [PW-1:0]      scan_start;
  logic [WORD_W-1:0]  mark_mask;

  bffa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_map_bits_in_use_i;
    end
  end

  always_comb begin
    if (32'(cfg_q) > MAP_CAPACITY) begin
      map_size = CFG_W'(MAP_CAPACITY);
    end else begin
      map_size = cfg_q;
    end
  end

  always_comb begin
    logic [PW-1:0] pos;
    scan_run   = run_q;
    scan_found = 1'b0;
    scan_end   = '0;
    for (int j = 0; j < WORD_W; j++) begin
      pos = {proc_q, BIT_W'(j)};
      if (!scan_found && (32'(pos) < 32'(map_size))) begin
        if (ram_rdata[j]) begin
          scan_run = '0;
        end else begin
          scan_run = scan_run + LEN_W'(1);
          if (scan_run == len_q) begin
            scan_found = 1'b1;
            scan_end   = pos;
          end
        end
      end
    end
    scan_start = scan_end + PW'(1) - PW'(len_q);
  end

  always_comb begin
    logic [PW-1:0] pos;
    for (int j = 0; j < WORD_W; j++) begin
      pos = {proc_q, BIT_W'(j)};
      mark_mask[j] = (pos >= start_q) && (pos <= end_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      issue_q     <= '0;
      proc_q      <= '0;
      last_q      <= '0;
      rd_vld_q    <= 1'b0;
      run_q       <= '0;
      clr_resp_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issue_q     <= issue_d;
      proc_q      <= proc_d;
      last_q      <= last_d;
      rd_vld_q    <= rd_vld_d;
      run_q       <= run_d;
      clr_resp_q  <= clr_resp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    idx_q        <= idx_d;
    len_q        <= len_d;
    val_q        <= val_d;
    start_q      <= start_d;
    end_q        <= end_d;
    res_failed_q <= res_failed_d;
    res_start_q  <= res_start_d;
    res_occ_q    <= res_occ_d;
    out_failed_q <= out_failed_d;
    out_start_q  <= out_start_d;
    out_occ_q    <= out_occ_d;
  end

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    idx_d        = idx_q;
    len_d        = len_q;
    val_d        = val_q;
    issue_d      = issue_q;
    proc_d       = proc_q;
    last_d       = last_q;
    rd_vld_d     = rd_vld_q;
    run_d        = run_q;
    start_d      = start_q;
    end_d        = end_q;
    clr_resp_d   = clr_resp_q;
    res_failed_d = res_failed_q;
    res_start_d  = res_start_q;
    res_occ_d    = res_occ_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_failed_d = out_failed_q;
    out_start_d  = out_start_q;
    out_occ_d    = out_occ_q;
    in_ready_o   = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = proc_q;
    ram_wdata    = '0;
    ram_raddr    = issue_q;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = issue_q;
        ram_wdata = '0;
        if (issue_q == AW'(DEPTH - 1)) begin
          issue_d    = '0;
          clr_resp_d = 1'b0;
          if (clr_resp_q) begin
            res_failed_d = 1'b0;
            res_start_d  = '0;
            res_occ_d    = 1'b0;
            state_d      = ST_RESP;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          issue_d = issue_q + AW'(1);
        end
      end

      ST_IDLE: begin
        in_ready_o = 1'b1;
        ram_raddr  = AW'(bit_pos_i >> BIT_W);
        if (in_valid_i) begin
          req_d        = req_type_e'(req_type_i);
          idx_d        = bit_pos_i;
          len_d        = run_length_i;
          val_d        = set_value_i;
          res_failed_d = 1'b1;
          res_start_d  = '0;
          res_occ_d    = 1'b0;
          unique case (req_type_e'(req_type_i))
            REQ_ALLOC: begin
              if ((run_length_i == '0) || (run_length_i > map_size)) begin
                state_d = ST_RESP;
              end else begin
                issue_d  = '0;
                proc_d   = '0;
                rd_vld_d = 1'b0;
                run_d    = '0;
                last_d   = AW'((map_size - CFG_W'(1)) >> BIT_W);
                state_d  = ST_SCAN;
              end
            end
            REQ_SET, REQ_STATUS: begin
              if (CFG_W'(bit_pos_i) >= map_size) begin
                state_d = ST_RESP;
              end else begin
                state_d = ST_BIT;
              end
            end
            REQ_CLEAR: begin
              issue_d    = '0;
              clr_resp_d = 1'b1;
              state_d    = ST_CLEAR;
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end

      ST_BIT: begin
        ram_waddr    = AW'(idx_q >> BIT_W);
        ram_wdata    = ram_rdata;
        ram_wdata[idx_q[BIT_W-1:0]] = val_q;
        ram_we       = (req_q == REQ_SET);
        res_failed_d = 1'b0;
        res_start_d  = '0;
        res_occ_d    = (req_q == REQ_STATUS) ? ram_rdata[idx_q[BIT_W-1:0]] : 1'b0;
        state_d      = ST_RESP;
      end

      ST_SCAN: begin
        rd_vld_d = 1'b1;
        issue_d  = (issue_q == last_q) ? issue_q : issue_q + AW'(1);
        if (rd_vld_q) begin
          run_d  = scan_run;
          proc_d = proc_q + AW'(1);
          if (scan_found) begin
            start_d  = scan_start;
            end_d    = scan_end;
            issue_d  = scan_start[PW-1:BIT_W];
            proc_d   = scan_start[PW-1:BIT_W];
            last_d   = scan_end[PW-1:BIT_W];
            rd_vld_d = 1'b0;
            state_d  = ST_MARK;
          end else if (proc_q == last_q) begin
            state_d = ST_RESP;
          end
        end
      end

      ST_MARK: begin
        rd_vld_d = 1'b1;
        issue_d  = (issue_q == last_q) ? issue_q : issue_q + AW'(1);
        if (rd_vld_q) begin
          ram_we    = 1'b1;
          ram_waddr = proc_q;
          ram_wdata = ram_rdata | mark_mask;
          proc_d    = proc_q + AW'(1);
          if (proc_q == last_q) begin
            res_failed_d = 1'b0;
            res_start_d  = IDX_W'(start_q);
            res_occ_d    = 1'b0;
            state_d      = ST_RESP;
          end
        end
      end

      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_failed_d = res_failed_q;
          out_start_d  = res_start_q;
          out_occ_d    = res_occ_q;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign failed_o    = out_failed_q;
  assign run_start_o = out_start_q;
  assign bit_busy_o  = out_occ_q;

endmodule

>>> verif/tb.sv
module tb;
  import bffa_pkg::*;

  typedef struct packed {
    logic             failed;
    logic [IDX_W-1:0] run_start;
    logic             bit_busy;
  } alloc_result_t;

  logic             clk          = 1'b0;
  logic             rst_n        = 1'b0;
  logic             cfg_valid    = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_map_bits = CFG_RESET;
  logic             req_valid    = 1'b0;
  logic             req_ready;
  logic [REQ_W-1:0] req_type     = REQ_STATUS;
  logic [IDX_W-1:0] bit_pos      = '0;
  logic [LEN_W-1:0] run_length   = '0;
  logic             set_value    = 1'b0;
  logic             rsp_valid;
  logic             rsp_ready    = 1'b0;
  logic             failed;
  logic [IDX_W-1:0] run_start;
  logic             bit_busy;

  bit            occupancy_shadow [MAP_CAPACITY_DEF];
  int unsigned   map_bits_shadow = 4096;
  alloc_result_t pending_alloc_results [$];
  int unsigned   mismatch_count = 0;
  bit            traffic_gaps = 1'b1;

  bitmap_first_fit_allocator_unit dut (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .cfg_valid_i           (cfg_valid),
    .cfg_ready_o           (cfg_ready),
    .cfg_map_bits_in_use_i (cfg_map_bits),
    .in_valid_i            (req_valid),
    .in_ready_o            (req_ready),
    .req_type_i            (req_type),
    .bit_pos_i             (bit_pos),
    .run_length_i          (run_length),
    .set_value_i           (set_value),
    .out_valid_o           (rsp_valid),
    .out_ready_i           (rsp_ready),
    .failed_o              (failed),
    .run_start_o           (run_start),
    .bit_busy_o            (bit_busy)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    mismatch_count++;
    $display("ERROR at %0t: %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  function automatic alloc_result_t compute_alloc_result(input req_type_e kind,
                                                         input logic [IDX_W-1:0] idx,
                                                         input logic [LEN_W-1:0] len,
                                                         input logic val);
    alloc_result_t res;
    int unsigned   size;
    int unsigned   run;
    int unsigned   pos;
    int unsigned   first;
    bit            found;
    res   = '0;
    run   = 0;
    first = 0;
    found = 1'b0;
    size  = (map_bits_shadow > MAP_CAPACITY_DEF) ? MAP_CAPACITY_DEF : map_bits_shadow;
    case (kind)
      REQ_ALLOC: begin
        res.failed = 1'b1;
        if (len != 0 && len <= size) begin
          for (pos = 0; pos < size && !found; pos++) begin
            if (occupancy_shadow[pos]) begin
              run = 0;
            end else begin
              run++;
              if (run == len) begin
                found = 1'b1;
                first = pos + 1 - len;
              end
            end
          end
        end
        if (found) begin
          for (pos = first; pos < first + len; pos++) occupancy_shadow[pos] = 1'b1;
          res.failed    = 1'b0;
          res.run_start = IDX_W'(first);
        end
      end
      REQ_SET: begin
        if (idx < size) occupancy_shadow[idx] = val;
        else res.failed = 1'b1;
      end
      REQ_STATUS: begin
        if (idx < size) res.bit_busy = occupancy_shadow[idx];
        else res.failed = 1'b1;
      end
      default: begin
        foreach (occupancy_shadow[i]) occupancy_shadow[i] = 1'b0;
      end
    endcase
    return res;
  endfunction

  task automatic send_request(input req_type_e kind, input int unsigned idx,
                              input int unsigned len, input bit val);
    @(negedge clk);
    if (traffic_gaps && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    req_valid  <= 1'b1;
    req_type   <= kind;
    bit_pos    <= IDX_W'(idx);
    run_length <= LEN_W'(len);
    set_value  <= val;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    pending_alloc_results.push_back(
      compute_alloc_result(kind, IDX_W'(idx), LEN_W'(len), val));
  endtask

  task automatic wait_for_results;
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_alloc_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_map_bits(input int unsigned bits);
    wait_for_results;
    @(negedge clk);
    cfg_valid    <= 1'b1;
    cfg_map_bits <= CFG_W'(bits);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    map_bits_shadow = bits & 32'h1FFF;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always begin : rsp_stalls
    @(negedge clk);
    if (traffic_gaps && $urandom_range(0, 5) == 0) begin
      rsp_ready <= 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    alloc_result_t got;
    alloc_result_t want;
    if (rst_n && rsp_valid && rsp_ready) begin
      got = {failed, run_start, bit_busy};
      if (pending_alloc_results.size() == 0) begin
        report_mismatch("result with no request pending", 0, 32'(got));
      end else begin
        want = pending_alloc_results.pop_front();
        if (got.failed !== want.failed) begin
          report_mismatch("failed", 32'(want.failed), 32'(got.failed));
        end
        if (got.run_start !== want.run_start) begin
          report_mismatch("run_start", 32'(want.run_start), 32'(got.run_start));
        end
        if (got.bit_busy !== want.bit_busy) begin
          report_mismatch("bit_busy", 32'(want.bit_busy), 32'(got.bit_busy));
        end
      end
    end
  end

  task automatic test_reset_state;
    send_request(REQ_STATUS, 0, 0, 1'b0);
    send_request(REQ_STATUS, MAP_CAPACITY_DEF - 1, 0, 1'b1);
  endtask

  task automatic test_set_and_status;
    send_request(REQ_SET, 4095, 0, 1'b1);
    send_request(REQ_STATUS, 4095, 0, 1'b0);
    send_request(REQ_SET, 2730, 0, 1'b1);
    send_request(REQ_STATUS, 1365, 0, 1'b0);
  endtask

  task automatic test_alloc_limits;
    send_request(REQ_ALLOC, 0, 0, 1'b0);
    send_request(REQ_ALLOC, 0, 8191, 1'b0);
    send_request(REQ_ALLOC, 0, 4096, 1'b0);
    send_request(REQ_ALLOC, 0, 1, 1'b0);
    send_request(REQ_ALLOC, 0, 1364, 1'b0);
    send_request(REQ_CLEAR, 0, 0, 1'b0);
    send_request(REQ_ALLOC, 0, 4096, 1'b0);
    send_request(REQ_CLEAR, 0, 0, 1'b0);
  endtask

  task automatic test_map_size;
    write_map_bits(0);
    send_request(REQ_ALLOC, 0, 1, 1'b0);
    send_request(REQ_STATUS, 0, 0, 1'b0);
    write_map_bits(13);
    send_request(REQ_STATUS, 13, 0, 1'b0);
    send_request(REQ_ALLOC, 0, 13, 1'b0);
    send_request(REQ_ALLOC, 0, 1, 1'b0);
    write_map_bits(8191);
    send_request(REQ_ALLOC, 0, 4096, 1'b0);
    // The clear must also free the bits that lie beyond a small map.
    write_map_bits(16);
    send_request(REQ_CLEAR, 0, 0, 1'b0);
    write_map_bits(4096);
    send_request(REQ_STATUS, 4095, 0, 1'b0);
    write_map_bits(1);
    send_request(REQ_ALLOC, 0, 1, 1'b0);
    send_request(REQ_ALLOC, 0, 1, 1'b0);
  endtask

  task automatic run_random_requests(input int unsigned num_req);
    int unsigned size;
    int unsigned pick;
    int unsigned idx;
    int unsigned len;
    size = (map_bits_shadow > MAP_CAPACITY_DEF) ? MAP_CAPACITY_DEF : map_bits_shadow;
    for (int unsigned n = 0; n < num_req; n++) begin
      pick = $urandom_range(0, 99);
      idx  = (size != 0 && $urandom_range(0, 9) != 0) ? $urandom_range(0, size - 1)
                                                       : $urandom_range(0, 4095);
      len  = $urandom_range(1, size / 8 + 1);
      if (pick < 45) begin
        send_request(REQ_ALLOC, idx, len, 1'($urandom_range(0, 1)));
      end else if (pick < 50) begin
        send_request(REQ_ALLOC, idx, $urandom_range(0, 8191), 1'($urandom_range(0, 1)));
      end else if (pick < 70) begin
        send_request(REQ_SET, idx, len, $urandom_range(0, 3) == 0);
      end else if (pick < 97) begin
        send_request(REQ_STATUS, idx, len, 1'($urandom_range(0, 1)));
      end else begin
        send_request(REQ_CLEAR, idx, len, 1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 99) == 0) wait_for_results;
    end
  endtask

  task automatic test_random_traffic;
    write_map_bits(64);
    run_random_requests(150);
    write_map_bits(13);
    run_random_requests(60);
    write_map_bits(1024);
    run_random_requests(110);
    write_map_bits(8191);
    run_random_requests(60);
    write_map_bits(256);
    run_random_requests(110);
    wait_for_results;
    traffic_gaps = 1'b0;
    write_map_bits(200);
    run_random_requests(160);
  endtask

  initial begin : main_sequence
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_state;
    test_set_and_status;
    test_alloc_limits;
    test_map_size;
    test_random_traffic;
    wait_for_results;
    repeat (20) @(posedge clk);
    if (pending_alloc_results.size() != 0) begin
      report_mismatch("requests left without a result", 0,
                      $unsigned(pending_alloc_results.size()));
    end
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
